// File: rtl/car_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package car_pkg;

    // frame characters
    localparam logic [7:0] CH_BANG = 8'h21;  // '!'
    localparam logic [7:0] CH_R    = 8'h52;  // 'R'
    localparam logic [7:0] CH_S    = 8'h53;  // 'S'
    localparam logic [7:0] CH_T    = 8'h54;  // 'T'
    localparam logic [7:0] CH_O    = 8'h4F;  // 'O'
    localparam logic [7:0] CH_K    = 8'h4B;  // 'K'
    localparam logic [7:0] CH_HASH = 8'h23;  // '#'

    localparam int RESEND_W = 16;
    localparam logic [RESEND_W-1:0] RESEND_RESET = 16'd300;

    // input kind carried in tuser
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // frames completed by the current byte
    typedef struct packed {
        logic rst_hit;
        logic ok_hit;
    } car_hits_t;

endpackage

`default_nettype wire

// File: rtl/command_ack_report_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            contents
// s_axis    in         s_tvalid / s_tready  tuser: mode; tdata: rx_byte, adc_sample
// m_axis    out        m_tvalid / m_tready  tdata: send_report, report_value, awaiting_ack
// cfg       in         cfg_valid/cfg_ready  cfg_data: resend_ticks
//
// one result per request, registered when the request is taken
// a new request is taken every cycle while the result register is empty or being drained
// the result register alone decides stalls: a held result blocks only the next request
// reset: parser idle, exchange idle, flags and countdown cleared, resend_ticks = 300
// config port is always ready and takes effect on the next request

module command_ack_report_engine
    import car_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    localparam int IN_W  = ((8 + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 + SAMPLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_tuser,    // [0] mode (0 byte, 1 tick)
    input  wire logic [IN_W-1:0]        s_tdata,    // [7:0] rx_byte, then adc_sample
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_W-1:0]            m_tdata,    // [0] send_report, report_value,
                                                    // then awaiting_ack
    // config write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RESEND_W-1:0]    cfg_data    // resend_ticks
);

    localparam int AWAIT_BIT = SAMPLE_BITS + 1;

    typedef enum logic {
        EX_IDLE,
        EX_WAIT
    } exchange_state_t;

    logic                   accept;
    logic                   mode;
    logic [7:0]             rx_byte;
    logic [SAMPLE_BITS-1:0] adc_sample;
    car_hits_t              hits;

    logic [RESEND_W-1:0]    resend_reg;
    exchange_state_t        ex_reg,   ex_next;
    logic                   rst_pend_reg, rst_pend_next;
    logic                   ack_pend_reg, ack_pend_next;
    logic [RESEND_W-1:0]    count_reg, count_next;
    logic                   expired_reg, expired_next;
    logic [SAMPLE_BITS-1:0] held_reg, held_next;
    logic                   send_next;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;

    assign mode       = s_tuser;
    assign rx_byte    = s_tdata[7:0];
    assign adc_sample = s_tdata[8 +: SAMPLE_BITS];

    // result register parts the two sides
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    car_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept && (mode == MODE_BYTE)),
        .rx_byte (rx_byte),
        .hits    (hits)
    );

    // byte or tick first, then one step of the exchange machine
    always_comb
    begin
        rst_pend_next = rst_pend_reg;
        ack_pend_next = ack_pend_reg;
        count_next    = count_reg;
        expired_next  = expired_reg;
        held_next     = held_reg;
        ex_next       = ex_reg;
        send_next     = 1'b0;

        if (mode == MODE_BYTE)
        begin
            // pending flags raise on the closing '#'
            rst_pend_next = rst_pend_reg || hits.rst_hit;
            ack_pend_next = ack_pend_reg || hits.ok_hit;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - RESEND_W'(1);
            if (count_reg == RESEND_W'(1))
            begin
                expired_next = 1'b1;
            end
        end

        case (ex_reg)
            EX_IDLE:
            begin
                if (rst_pend_next)
                begin
                    rst_pend_next = 1'b0;
                    held_next     = adc_sample;
                    send_next     = 1'b1;
                    count_next    = resend_reg;
                    expired_next  = 1'b0;
                    ex_next       = EX_WAIT;
                end
            end
            EX_WAIT:
            begin
                if (ack_pend_next)
                begin
                    // acknowledge ends the exchange; expired is unused while idle
                    ack_pend_next = 1'b0;
                    expired_next  = 1'b1;
                    ex_next       = EX_IDLE;
                end
                else if (expired_next)
                begin
                    // resend the held value and rearm
                    send_next    = 1'b1;
                    count_next   = resend_reg;
                    expired_next = 1'b0;
                end
            end
            default:
            begin
                ex_next = EX_IDLE;
            end
        endcase

        out_data_next                       = '0;
        out_data_next[0]                    = send_next;
        out_data_next[1 +: SAMPLE_BITS]     = held_next;
        out_data_next[AWAIT_BIT]            = (ex_next == EX_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resend_reg    <= RESEND_RESET;
            ex_reg        <= EX_IDLE;
            rst_pend_reg  <= 1'b0;
            ack_pend_reg  <= 1'b0;
            count_reg     <= '0;
            expired_reg   <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                resend_reg <= cfg_data;
            end
            if (accept)
            begin
                ex_reg       <= ex_next;
                rst_pend_reg <= rst_pend_next;
                ack_pend_reg <= ack_pend_next;
                count_reg    <= count_next;
                expired_reg  <= expired_next;
                held_reg     <= held_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // every taken request leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("request taken without a result");

    // a new request never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

    // a report is only sent while the exchange waits for an acknowledgement
    a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[AWAIT_BIT])
        else $error("report sent outside an exchange");

endmodule

`default_nettype wire

// File: rtl/car_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module car_parser
    import car_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output car_hits_t       hits
);

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_START,
        PS_R,
        PS_S,
        PS_T,
        PS_O,
        PS_K
    } parse_state_t;

    parse_state_t state_reg;
    parse_state_t state_next;

    always_comb
    begin
        state_next   = PS_IDLE;
        hits.rst_hit = 1'b0;
        hits.ok_hit  = 1'b0;
        if (rx_byte == CH_BANG)
        begin
            state_next = PS_START;
        end
        else
        begin
            case (state_reg)
                PS_START:
                begin
                    if (rx_byte == CH_R)
                    begin
                        state_next = PS_R;
                    end
                    else if (rx_byte == CH_O)
                    begin
                        state_next = PS_O;
                    end
                end
                PS_R:    if (rx_byte == CH_S) state_next = PS_S;
                PS_S:    if (rx_byte == CH_T) state_next = PS_T;
                PS_T:    hits.rst_hit = (rx_byte == CH_HASH);
                PS_O:    if (rx_byte == CH_K) state_next = PS_K;
                PS_K:    hits.ok_hit = (rx_byte == CH_HASH);
                default: state_next = PS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/command_ack_report_engine_test.sv
`timescale 1ns / 1ps

module command_ack_report_engine_test;
    import car_pkg::*;

    localparam int SAMPLE_W    = 12;
    localparam int IN_W        = 24;   // rx_byte + sample, padded to bytes
    localparam int OUT_W       = 16;   // send + value + awaiting, padded to bytes
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_CYCLES = 250;  // long receiver hold-off
    localparam int HOLD_AFTER  = 300;  // results seen before the hold-off starts
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 12;

    // parser position within a frame
    typedef enum logic [2:0] {
        P_IDLE,
        P_BANG,
        P_R,
        P_S,
        P_T,
        P_O,
        P_K
    } frame_pos_t;

    typedef struct {
        logic                mode;
        logic [7:0]          rx_byte;
        logic [SAMPLE_W-1:0] adc_sample;
    } request_t;

    typedef struct {
        logic                send_report;
        logic [SAMPLE_W-1:0] report_value;
        logic                awaiting_ack;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic                s_tuser = 1'b0;     // [0] mode
    logic [IN_W-1:0]     s_tdata = '0;       // [7:0] rx_byte, [19:8] adc_sample
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;            // [0] send_report, [12:1] report_value,
                                             // [13] awaiting_ack
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RESEND_W-1:0] cfg_data = '0;

    // stimulus and scoreboard
    request_t request_q[$];
    report_t  report_due[$];
    request_t on_wire;
    int       fail_count = 0;
    int       results_seen = 0;
    int       stall_cycles = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       calm = 1'b0;       // no random idling on either side

    // shadow of the engine state
    logic [RESEND_W-1:0] resend_copy = RESEND_RESET;
    frame_pos_t          frame_pos = P_IDLE;
    logic                waiting = 1'b0;
    logic                reset_seen = 1'b0;
    logic                ack_flag = 1'b0;
    logic [RESEND_W-1:0] ticks_left = '0;
    logic                timed_out = 1'b0;
    logic [SAMPLE_W-1:0] held = '0;

    always #2 clk = ~clk;

    command_ack_report_engine #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // advance the shadow state by one request and queue the report it yields
    function automatic void next_report(input request_t r);
        report_t e;
        e.send_report = 1'b0;
        // byte parsing or tick counting comes first
        if (r.mode == MODE_BYTE)
        begin
            if (r.rx_byte == CH_BANG)
            begin
                frame_pos = P_BANG;     // a bang always restarts a frame
            end
            else
            begin
                case (frame_pos)
                    P_BANG:
                        frame_pos = (r.rx_byte == CH_R) ? P_R :
                                    (r.rx_byte == CH_O) ? P_O : P_IDLE;
                    P_R:
                        frame_pos = (r.rx_byte == CH_S) ? P_S : P_IDLE;
                    P_S:
                        frame_pos = (r.rx_byte == CH_T) ? P_T : P_IDLE;
                    P_O:
                        frame_pos = (r.rx_byte == CH_K) ? P_K : P_IDLE;
                    P_T:
                    begin
                        if (r.rx_byte == CH_HASH)
                            reset_seen = 1'b1;
                        frame_pos = P_IDLE;
                    end
                    P_K:
                    begin
                        if (r.rx_byte == CH_HASH)
                            ack_flag = 1'b1;
                        frame_pos = P_IDLE;
                    end
                    default:
                        frame_pos = P_IDLE;
                endcase
            end
        end
        else if (ticks_left != '0)
        begin
            ticks_left = ticks_left - RESEND_W'(1);
            if (ticks_left == '0)
                timed_out = 1'b1;
        end
        // then the exchange machine acts once
        if (!waiting)
        begin
            if (reset_seen)
            begin
                reset_seen    = 1'b0;
                held          = r.adc_sample;
                e.send_report = 1'b1;
                ticks_left    = resend_copy;
                timed_out     = 1'b0;
                waiting       = 1'b1;
            end
        end
        else if (ack_flag)
        begin
            ack_flag  = 1'b0;
            timed_out = 1'b1;
            waiting   = 1'b0;
        end
        else if (timed_out)
        begin
            e.send_report = 1'b1;
            ticks_left    = resend_copy;
            timed_out     = 1'b0;
        end
        e.report_value = held;
        e.awaiting_ack = waiting;
        report_due.push_back(e);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_requests
        logic offer;
        offer = s_tvalid;
        if (s_tvalid && s_tready)
        begin
            next_report(on_wire);
            offer = 1'b0;
        end
        if (!offer && rst_n && request_q.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            on_wire = request_q.pop_front();
            s_tuser <= on_wire.mode;
            s_tdata <= {{(IN_W-8-SAMPLE_W){1'b0}}, on_wire.adc_sample, on_wire.rx_byte};
            offer = 1'b1;
        end
        s_tvalid <= offer;
    end

    // result monitor, also owns the long hold-off
    always @(posedge clk)
    begin : watch_reports
        report_t want;
        logic    go;
        if (m_tvalid && m_tready)
        begin
            if (report_due.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = report_due.pop_front();
                check_field("send_report", want.send_report, m_tdata[0]);
                check_field("report_value", want.report_value, m_tdata[SAMPLE_W:1]);
                check_field("awaiting_ack", want.awaiting_ack, m_tdata[SAMPLE_W+1]);
            end
            results_seen++;
        end
        if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            go = 1'b0;
        end
        else
        begin
            go = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
        m_tready <= go;
    end

    // watchdog: only counts while something is still owed
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            (request_q.size() == 0 && !s_tvalid && report_due.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_request(input logic mode, input int rx_byte, input int sample);
        request_t r;
        r.mode       = mode;
        r.rx_byte    = rx_byte[7:0];
        r.adc_sample = (sample < 0) ? SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1))
                                    : SAMPLE_W'(sample);
        request_q.push_back(r);
    endtask

    // a run of bytes; negative sample means a fresh random sample per byte
    task automatic push_text(input string txt, input int sample);
        for (int i = 0; i < txt.len(); i++)
            push_request(MODE_BYTE, txt[i], sample);
    endtask

    task automatic push_random(input int count);
        int    made;
        int    pick;
        int    cut;
        string frame;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                push_text("!RST#", -1);
                made += 5;
            end
            else if (pick < 50)
            begin
                push_text("!OK#", -1);
                made += 4;
            end
            else if (pick < 80)
            begin
                cut = $urandom_range(1, 8);
                repeat (cut) push_request(MODE_TICK, $urandom_range(0, 255), -1);
                made += cut;
            end
            else if (pick < 90)
            begin
                push_request(MODE_BYTE, $urandom_range(0, 255), -1);
                made++;
            end
            else
            begin
                // broken frame: a prefix followed by a stray byte
                frame = ($urandom_range(0, 1) != 0) ? "!RST#" : "!OK#";
                cut = $urandom_range(1, frame.len() - 1);
                push_text(frame.substr(0, cut - 1), -1);
                push_request(MODE_BYTE, $urandom_range(0, 255), -1);
                made += cut + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || report_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_resend(input logic [RESEND_W-1:0] ticks);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        resend_copy = ticks;
    endtask

    initial
    begin
        logic [RESEND_W-1:0] resend_plan[6];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset value of the resend period still in force
        push_text("A", 0);                              // ignored while idle
        push_request(MODE_TICK, 8'hFF, 4095);           // tick with countdown at zero
        push_text("!OK#", -1);                          // stale ack while idle
        push_text("!RST#", 4095);                       // report, stale ack ends it next
        push_request(MODE_TICK, 8'h00, 0);
        push_text("!R!RST#", 12'hA5A);                  // bang restarts a frame
        push_request(MODE_BYTE, 8'hFF, 0);
        push_request(MODE_BYTE, 8'h00, 4095);
        push_text("!OK#", 0);                           // ack while waiting
        wait_drained();

        resend_plan[0] = 16'd1;
        resend_plan[1] = 16'd0;                         // never expires
        resend_plan[2] = 16'hFFFF;
        resend_plan[3] = RESEND_W'($urandom_range(2, 6));
        resend_plan[4] = 16'd3;
        resend_plan[5] = RESEND_W'($urandom_range(1, 9));
        for (int p = 0; p < 6; p++)
        begin
            set_resend(resend_plan[p]);
            calm = (p == 4);
            push_random(PHASE_ITEMS);
            wait_drained();
        end
        calm = 1'b0;

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
